>>> hdl/round_robin_time_slice_scheduler_assert.svh
// assertion macros for the round-robin time-slice scheduler
// used by the top level only, expects a clock named clk and a reset named rst
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RRTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RRTS_ASSERT_IMPL(label, ante, cons, msg)
`define RRTS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/rrts_pkg.sv
// types and constants of the round-robin time-slice scheduler
// no dependencies
package rrts_pkg;

  typedef logic [7:0]  tag_t;
  typedef logic [15:0] time_t;
  typedef logic [31:0] total_t;

  localparam logic  OP_ADD           = 1'b0;
  localparam logic  OP_RUN           = 1'b1;
  localparam time_t TIME_SLICE_RESET = 16'd1;

  typedef struct packed {
    logic  operation;
    tag_t  process_tag;
    time_t need_time;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    logic   idle;
    tag_t   ran_tag;
    time_t  time_used;
    logic   finished;
    total_t elapsed_time;
  } out_item_t;

  typedef struct packed {
    tag_t  tag;
    time_t remaining;
  } entry_t;

  typedef struct packed {
    logic add;
    logic run_empty;
    logic run_start;
    logic run_exec;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } status_t;

endpackage

>>> hdl/rrts_chan_if.sv
// valid/ready channel carrying one payload per transfer
// payload type set by the instantiating level
interface rrts_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/rrts_ctrl.sv
// controller of the scheduler: handshakes, run sequencing, result valid
// depends on rrts_pkg
module rrts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rrts_pkg::status_t st,
  output rrts_pkg::cmd_t   cmd
);
  import rrts_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  logic   in_xfer;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cmd.add       = in_xfer && (in_op == OP_ADD);
    cmd.run_empty = in_xfer && (in_op == OP_RUN) && st.empty;
    cmd.run_start = in_xfer && (in_op == OP_RUN) && !st.empty;
    cmd.run_exec  = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.run_start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.add || cmd.run_empty || cmd.run_exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

>>> hdl/rrts_dpath.sv
// datapath of the scheduler: ready queue memory, pointers, elapsed counter,
// slice register and result register; depends on rrts_pkg
module rrts_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rrts_pkg::cmd_t      cmd,
  output rrts_pkg::status_t   st,
  input  rrts_pkg::in_item_t  item,
  input  logic                cfg_we,
  input  rrts_pkg::time_t     cfg_data,
  output rrts_pkg::out_item_t result
);
  import rrts_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_entry;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [CNT_W-1:0]   count;
  total_t             elapsed;
  time_t              time_slice;

  logic               mem_we;
  entry_t             mem_wdata;
  logic               fin;
  time_t              used;
  total_t             elapsed_next;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail_next;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  assign st.empty = (count == '0);
  assign st.full  = (count == CNT_W'(QUEUE_DEPTH));

  assign fin          = (rd_entry.remaining <= time_slice);
  assign used         = fin ? rd_entry.remaining : time_slice;
  assign elapsed_next = elapsed + {16'd0, used};
  assign head_next    = wrap_inc(head);
  assign tail_next    = wrap_inc(tail);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '{tag: item.process_tag, remaining: item.need_time};
    if (cmd.add && !st.full) begin
      mem_we = 1'b1;
    end else if (cmd.run_exec && !fin) begin
      mem_we    = 1'b1;
      mem_wdata = '{tag: rd_entry.tag, remaining: rd_entry.remaining - time_slice};
    end
  end

  // ready queue storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= mem_wdata;
    end
    rd_entry <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      elapsed    <= '0;
      time_slice <= TIME_SLICE_RESET;
    end else begin
      if (cfg_we) begin
        time_slice <= cfg_data;
      end
      if (cmd.add && !st.full) begin
        tail  <= tail_next;
        count <= count + CNT_W'(1);
      end
      if (cmd.run_exec) begin
        head    <= head_next;
        elapsed <= elapsed_next;
        if (fin) begin
          count <= count - CNT_W'(1);
        end else begin
          tail <= tail_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      result <= '{accepted: !st.full, idle: 1'b0, ran_tag: '0, time_used: '0,
                  finished: 1'b0, elapsed_time: elapsed};
    end else if (cmd.run_empty) begin
      result <= '{accepted: 1'b0, idle: 1'b1, ran_tag: '0, time_used: '0,
                  finished: 1'b0, elapsed_time: elapsed};
    end else if (cmd.run_exec) begin
      result <= '{accepted: 1'b0, idle: 1'b0, ran_tag: rd_entry.tag, time_used: used,
                  finished: fin, elapsed_time: elapsed_next};
    end
  end
endmodule

>>> hdl/round_robin_time_slice_scheduler.sv
// round-robin time-slice scheduler over a ready queue of QUEUE_DEPTH entries
// add: result registered in the cycle after the transfer; one add per cycle while each result is taken
// run: the transfer enters the execute state, which uses the registered read of the head entry from the queue memory
// a waiting result holds the input until the cycle in which it is taken
// reset clears pointers, entry count and elapsed counter, slice returns to 1;
// queue memory is not cleared
`include "round_robin_time_slice_scheduler_assert.svh"

module round_robin_time_slice_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  rrts_chan_if.sink   items,
  rrts_chan_if.source results,
  rrts_chan_if.sink   cfg
);
  import rrts_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg.ready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_op     (items.data.operation),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rrts_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .item     (items.data),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .result   (results.data)
  );

  `RRTS_ASSERT_NEXT(a_run_blocks_input, cmd.run_start, !items.ready, "input open during run")
  `RRTS_ASSERT_NEXT(a_add_gives_result, cmd.add, results.valid, "add without result")
  `RRTS_ASSERT_IMPL(a_add_result_clean, results.valid && results.data.accepted, !results.data.idle && !results.data.finished && (results.data.time_used == '0), "add result fields")
  `RRTS_ASSERT_IMPL(a_status_consistent, 1'b1, !(st.empty && st.full), "queue both empty and full")

endmodule

>>> bench/tb_top.sv
// testbench for the round-robin time-slice scheduler: directed and random adds and runs
// with random idling on both channels, checked by a scoreboard that tracks the ready queue
// depends on rrts_pkg, rrts_chan_if and round_robin_time_slice_scheduler
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int QDEPTH          = 16;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 190;

  class sched_scoreboard;
    entry_t    ready_q[$];
    out_item_t pending_results[$];
    total_t    clock_total;
    time_t     slice;
    int        errors;

    function new();
      clock_total = '0;
      slice       = TIME_SLICE_RESET;
      errors      = 0;
    endfunction

    function void apply_item(in_item_t it);
      out_item_t res;
      entry_t    head;
      res = '0;
      if (it.operation == OP_ADD) begin
        if (ready_q.size() < QDEPTH) begin
          ready_q.push_back('{tag: it.process_tag, remaining: it.need_time});
          res.accepted = 1'b1;
        end
      end else if (ready_q.size() == 0) begin
        res.idle = 1'b1;
      end else begin
        head        = ready_q.pop_front();
        res.ran_tag = head.tag;
        if (head.remaining <= slice) begin
          res.time_used = head.remaining;
          res.finished  = 1'b1;
        end else begin
          res.time_used = slice;
          ready_q.push_back('{tag: head.tag, remaining: head.remaining - slice});
        end
        clock_total = clock_total + total_t'(res.time_used);
      end
      res.elapsed_time = clock_total;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("idle", 32'(want.idle), 32'(got.idle));
      compare_field("ran_tag", 32'(want.ran_tag), 32'(got.ran_tag));
      compare_field("time_used", 32'(want.time_used), 32'(got.time_used));
      compare_field("finished", 32'(want.finished), 32'(got.finished));
      compare_field("elapsed_time", want.elapsed_time, got.elapsed_time);
    endfunction
  endclass

  logic            clk;
  logic            rst;
  int              send_idle_pct = 0;
  int              stall_pct     = 0;
  int              cycle_count   = 0;
  sched_scoreboard sb            = new();

  rrts_chan_if #(.T(in_item_t))  items_if ();
  rrts_chan_if #(.T(out_item_t)) results_if ();
  rrts_chan_if #(.T(time_t))     cfg_if ();

  round_robin_time_slice_scheduler #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if),
    .cfg    (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      sb.check_result(results_if.data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic op, input tag_t tag, input time_t need);
    in_item_t it;
    it.operation   = op;
    it.process_tag = tag;
    it.need_time   = need;
    if ($urandom_range(99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    do @(posedge clk); while (!items_if.ready);
    sb.apply_item(it);
  endtask

  task automatic write_slice(input time_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.slice = value;
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every outstanding result, then let the run pipeline empty
  task automatic settle();
    items_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int    add_pct;
    int    lim;
    int    pick;
    time_t need;
    add_pct = 50;
    for (int n = 0; n < count; n++) begin
      // bursts that fill, hover or drain the queue
      if (n % 20 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 80;
          1: add_pct = 50;
          default: add_pct = 20;
        endcase
      end
      lim = 3 * int'(sb.slice) + 2;
      if (lim > 65535) lim = 65535;
      pick = $urandom_range(99);
      if (pick < 8) need = '0;
      else if (pick < 16) need = '1;
      else if (pick < 28) need = time_t'($urandom_range(65535));
      else need = time_t'($urandom_range(lim, 1));
      send_item(($urandom_range(99) < add_pct) ? OP_ADD : OP_RUN,
                tag_t'($urandom_range(255)), need);
    end
  endtask

  initial begin
    time_t slice_plan[8];
    rst              <= 1'b1;
    items_if.valid   <= 1'b0;
    items_if.data    <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset slice: run on empty queue, zero need, extreme tags and need
    send_item(OP_RUN, 8'h3C, 16'h1234);
    send_item(OP_ADD, 8'h00, 16'h0000);
    send_item(OP_RUN, 8'h00, 16'h0000);
    send_item(OP_ADD, 8'hFF, 16'hFFFF);
    send_item(OP_ADD, 8'hA5, 16'h0001);
    send_item(OP_RUN, 8'hC3, 16'hFFFF);
    send_item(OP_RUN, 8'h5A, 16'h5555);
    send_item(OP_RUN, 8'h00, 16'hAAAA);
    settle();

    // fill the queue and overflow it by one
    write_slice(16'd2);
    for (int i = 1; i <= QDEPTH; i++) begin
      send_item(OP_ADD, tag_t'(i), time_t'(i));
    end
    settle();

    slice_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd4, 16'd12, 16'd2,
                   time_t'($urandom_range(65535, 1)), time_t'($urandom_range(40, 3))};
    for (int p = 0; p < 8; p++) begin
      write_slice(slice_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      random_phase(ITEMS_PER_PHASE);
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/rrts_pkg.sv
hdl/rrts_chan_if.sv
hdl/rrts_ctrl.sv
hdl/rrts_dpath.sv
hdl/round_robin_time_slice_scheduler.sv
bench/tb_top.sv
